@@ hdl/mfir_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mfir_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_MAX_TAPS     = 256;
    localparam int DEF_MAX_CHANNELS = 8;

    // Transaction field widths
    localparam int CHAN_W   = 3;
    localparam int TIDX_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int OUT_W    = 34;
    localparam int PROD_W   = SAMPLE_W + COEF_W;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [8:0] RST_TAP_COUNT     = 9'd16;
    localparam logic [3:0] RST_CHANNEL_COUNT = 4'd1;
    localparam int MIN_TAPS = 2;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Fixed-point rounding: Q1.15 x Q10.14 back to Q1.15 scale
    localparam int RND_SHIFT = 14;
    localparam int RND_BIAS  = 1 << (RND_SHIFT - 1);
    localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam longint OUT_MIN = -OUT_MAX - 64'sd1;

    typedef logic [CHAN_W-1:0]          t_chan;
    typedef logic [TIDX_W-1:0]          t_tap_idx;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [OUT_W-1:0]    t_filt;

    // Read-stage outputs of the sequencer toward the MAC
    typedef struct packed {
        logic                       vld;
        logic                       first;
        logic                       last;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [COEF_W-1:0]   coef;
    } t_mac_in;

endpackage

`default_nettype wire

@@ hdl/mfir_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface mfir_in_if import mfir_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     kind;
    t_chan    channel;
    t_tap_idx tap_index;
    t_sample  sample_value;
    t_coef    tap_value;

    modport source (output valid, kind, channel, tap_index, sample_value, tap_value,
                    input ready);
    modport sink   (input valid, kind, channel, tap_index, sample_value, tap_value,
                    output ready);
endinterface

// Result channel
interface mfir_out_if import mfir_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan out_channel;
    t_filt filtered;

    modport source (output valid, out_channel, filtered, input ready);
    modport sink   (input valid, out_channel, filtered, output ready);
endinterface

// Register write channel
interface mfir_cfg_if import mfir_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/mfir_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfir_seq import mfir_pkg::*; #(
    parameter int MAX_TAPS     = DEF_MAX_TAPS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mfir_cfg_if.sink    i_cfg,
    mfir_in_if.sink     i_in,
    input  wire logic   i_mac_busy,
    output t_mac_in     o_mac
);

    localparam int TAP_AW    = $clog2(MAX_TAPS);
    localparam int CNT_W     = $clog2(MAX_TAPS + 1);
    localparam int CH_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DLY_AW    = CH_AW + TAP_AW;
    localparam int DLY_DEPTH = 1 << DLY_AW;
    localparam int SUM_W     = TAP_AW + 1;

    localparam logic [TAP_AW-1:0] LAST_SLOT = TAP_AW'(MAX_TAPS - 1);
    localparam logic [CNT_W-1:0]  TAPS_MAX  = CNT_W'(MAX_TAPS);
    localparam logic [CNT_W-1:0]  TAPS_MIN  = CNT_W'(MIN_TAPS);
    localparam logic [SUM_W-1:0]  RING_LEN  = SUM_W'(MAX_TAPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [8:0]        r_tap_count;
    logic [3:0]        r_chan_count;
    logic [TAP_AW-1:0] r_wpos [MAX_CHANNELS];
    logic [CNT_W-1:0]  r_fill [MAX_CHANNELS];

    logic [CH_AW-1:0]  r_ch;
    logic [TAP_AW-1:0] r_slot;
    logic [TAP_AW-1:0] r_issue;
    logic [TAP_AW-1:0] r_last;
    logic              r_rd_vld;
    logic              r_rd_first;
    logic              r_rd_last;

    t_sample r_dly_mem [DLY_DEPTH];
    t_coef   r_tap_mem [MAX_TAPS];
    t_sample r_dly_q;
    t_coef   r_tap_q;

    logic              accept;
    logic              ch_ok;
    logic [CH_AW-1:0]  ch_idx;
    logic [CNT_W-1:0]  eff_taps;
    logic [TAP_AW-1:0] pos, pos_new;
    logic [CNT_W-1:0]  fill, fill_new;
    logic [SUM_W-1:0]  start_sum;
    logic [TAP_AW-1:0] start_slot;
    logic              tap_we, smp_we, go, rd_en;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign accept      = i_in.valid && i_in.ready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= RST_TAP_COUNT;
            r_chan_count <= RST_CHANNEL_COUNT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TAP_COUNT:     r_tap_count  <= i_cfg.data;
                CFG_CHANNEL_COUNT: r_chan_count <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // Effective tap count, clamped to the supported range
    always_comb begin
        if (r_tap_count < 9'(MIN_TAPS)) begin
            eff_taps = TAPS_MIN;
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            eff_taps = TAPS_MAX;
        end else begin
            eff_taps = CNT_W'(r_tap_count);
        end
    end

    // Channel in use: a zero count behaves as one channel
    always_comb begin
        if (r_chan_count == 4'd0) begin
            ch_ok = (i_in.channel == '0);
        end else begin
            ch_ok = (32'(i_in.channel) < 32'(r_chan_count)) &&
                    (32'(i_in.channel) < MAX_CHANNELS);
        end
    end

    // Ring pointer update and window start
    assign ch_idx     = CH_AW'(i_in.channel);
    assign pos        = r_wpos[ch_idx];
    assign fill       = r_fill[ch_idx];
    assign pos_new    = (pos == LAST_SLOT) ? '0 : pos + 1'b1;
    assign fill_new   = (fill < TAPS_MAX) ? fill + 1'b1 : fill;
    assign start_sum  = SUM_W'(pos_new) + RING_LEN - SUM_W'(eff_taps);
    assign start_slot = (start_sum >= RING_LEN) ? TAP_AW'(start_sum - RING_LEN)
                                                : TAP_AW'(start_sum);

    assign tap_we = accept && (i_in.kind == KIND_COEF) &&
                    (32'(i_in.tap_index) < MAX_TAPS);
    assign smp_we = accept && (i_in.kind == KIND_SAMPLE) && ch_ok;
    assign go     = smp_we && (fill_new >= eff_taps);
    assign rd_en  = (r_state == ST_RUN);

    // Per-channel ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_wpos[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (smp_we) begin
            r_wpos[ch_idx] <= pos_new;
            r_fill[ch_idx] <= fill_new;
        end
    end

    // Delay line memory
    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            r_dly_mem[{ch_idx, pos}] <= i_in.sample_value;
        end
        if (rd_en) begin
            r_dly_q <= r_dly_mem[{r_ch, r_slot}];
        end
    end

    // Coefficient memory
    always_ff @(posedge i_clk) begin
        if (tap_we) begin
            r_tap_mem[TAP_AW'(i_in.tap_index)] <= i_in.tap_value;
        end
        if (rd_en) begin
            r_tap_q <= r_tap_mem[r_issue];
        end
    end

    // Walk over the window
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_ch    <= ch_idx;
            r_slot  <= start_slot;
            r_issue <= '0;
            r_last  <= TAP_AW'(eff_taps - 1'b1);
        end else if (rd_en) begin
            r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            r_issue <= r_issue + 1'b1;
        end
    end

    // Read-stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
        r_rd_first <= (r_issue == '0);
        r_rd_last  <= (r_issue == r_last);
    end

    // Control FSM
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (go) n_state = ST_RUN;
            ST_RUN:  if (r_issue == r_last) n_state = ST_WAIT;
            ST_WAIT: if (!r_rd_vld && !i_mac_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_mac.vld     = r_rd_vld;
    assign o_mac.first   = r_rd_first;
    assign o_mac.last    = r_rd_last;
    assign o_mac.channel = CHAN_W'(r_ch);
    assign o_mac.sample  = r_dly_q;
    assign o_mac.coef    = r_tap_q;

endmodule

`default_nettype wire

@@ hdl/mfir_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfir_mac import mfir_pkg::*; #(
    parameter int MAX_TAPS = DEF_MAX_TAPS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_mac_in     i_mac,
    output logic        o_busy,
    mfir_out_if.source  o_out
);

    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
    localparam int RW    = ACC_W + 1;
    localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
    localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_mul_vld;
    logic                     r_mul_first;
    logic                     r_mul_last;
    t_chan                    r_mul_ch;
    logic signed [ACC_W-1:0]  r_acc;
    t_chan                    r_acc_ch;
    logic                     r_pend;
    logic                     r_out_vld;
    t_chan                    r_out_ch;
    t_filt                    r_out_filt;

    logic signed [RW-1:0]     sum_rnd;
    logic signed [RW-1:0]     rnd;
    t_filt                    sat;
    logic                     out_free;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld <= 1'b0;
        end else begin
            r_mul_vld <= i_mac.vld;
        end
        r_prod      <= $signed(i_mac.sample) * $signed(i_mac.coef);
        r_mul_first <= i_mac.first;
        r_mul_last  <= i_mac.last;
        r_mul_ch    <= i_mac.channel;
    end

    // Accumulate stage; first term restarts the sum
    always_ff @(posedge i_clk) begin
        if (r_mul_vld) begin
            r_acc <= (r_mul_first ? '0 : r_acc) + ACC_W'(r_prod);
        end
        if (r_mul_vld && r_mul_last) begin
            r_acc_ch <= r_mul_ch;
        end
    end

    // Round half up, shift, saturate
    assign sum_rnd = RW'(r_acc) + RW'(RND_BIAS);
    assign rnd     = sum_rnd >>> RND_SHIFT;

    always_comb begin
        if (rnd > SAT_HI) begin
            sat = OUT_W'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            sat = OUT_W'(SAT_LO);
        end else begin
            sat = OUT_W'(rnd);
        end
    end

    assign out_free = !r_out_vld || o_out.ready;

    // Finished sum waits here until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (r_mul_vld && r_mul_last) begin
            r_pend <= 1'b1;
        end else if (out_free) begin
            r_pend <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (r_pend && out_free) begin
            r_out_ch   <= r_acc_ch;
            r_out_filt <= sat;
        end
    end

    assign o_busy            = r_mul_vld || r_pend;
    assign o_out.valid       = r_out_vld;
    assign o_out.out_channel = r_out_ch;
    assign o_out.filtered    = r_out_filt;

endmodule

`default_nettype wire

@@ hdl/multichannel_fir_filter.sv @@
// A sample that completes a window gives its result after one delay/coefficient memory
//   read per tap, then multiply, accumulate, round and output register.
// Such a sample holds the input until the single shared multiply-accumulate has drained
//   and its result has moved to the output register; coefficient loads and other samples do not.
// Reset: synchronous, active low; restores the tap and channel count registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module multichannel_fir_filter import mfir_pkg::*; #(
    parameter int MAX_TAPS     = DEF_MAX_TAPS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mfir_cfg_if.sink   i_cfg,
    mfir_in_if.sink    i_in,
    mfir_out_if.source o_out
);

    t_mac_in mac_in;
    logic    mac_busy;

    // Ring pointers, memories and tap sequencing
    mfir_seq #(
        .MAX_TAPS     (MAX_TAPS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_in       (i_in),
        .i_mac_busy (mac_busy),
        .o_mac      (mac_in)
    );

    // Multiply-accumulate and result stage
    mfir_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mac   (mac_in),
        .o_busy  (mac_busy),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
